[rtl/pns_pkg.sv]
package pns_pkg;

  // Default number of segments the vertex store is sized for.
  localparam int MAX_SEGMENTS_DEF = 1024;

  // Configuration register indexes.
  localparam logic REG_SEGMENT_COUNT = 1'b0;
  localparam logic REG_CLOSED_LOOP   = 1'b1;

  // Request kinds on the input channel.
  localparam logic KIND_LOAD  = 1'b0;
  localparam logic KIND_QUERY = 1'b1;

  // Iteration lengths of the shared sequential units.
  localparam int MUL_STEPS  = 7;
  localparam int PSI_STEPS  = 17;
  localparam int SQRT_STEPS = 33;
  localparam int DIV_STEPS  = 32;

  // One in Q1.16 for the position on a segment.
  localparam logic signed [17:0] PSI_ONE = 18'sd65536;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_RDA,
    ST_RDB,
    ST_DIFF,
    ST_MUL,
    ST_CHK,
    ST_PSI,
    ST_SQRT,
    ST_DSET,
    ST_DIV,
    ST_UPD,
    ST_DONE
  } state_t;

endpackage

[rtl/pns_ram.sv]
module pns_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1025
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port and one registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[rtl/polyline_nearest_segment_search.sv]
// Nearest-segment search on a stored 2D polyline. A load request (kind 0) writes one
// Q16.16 vertex into the x and y vertex memories; slots above MAX_SEGMENTS are
// ignored. A query request (kind 1) walks segment k = vertex k to vertex k+1 for
// every segment in use, plus the last segment once more up front in closed-loop
// mode, and returns one result. Each segment goes through one shared iterative
// datapath: two memory reads and a difference step, a single 33x33 multiplier used
// six times, a check, a 17-step position divide only when the point projects inside
// the segment, a 33-step square root, a setup, a 32-step distance divide unless the
// distance saturates, and an update. Zero-length segments go from the check straight
// to the update. The result register lets a new request be taken while a result
// waits on the output.
module polyline_nearest_segment_search #(
  parameter int MAX_SEGMENTS = pns_pkg::MAX_SEGMENTS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  // Input channel
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               in_kind,
  input  logic [10:0]        in_vertex_index,
  input  logic signed [31:0] in_coord_x,
  input  logic signed [31:0] in_coord_y,
  // Result channel
  output logic               out_valid,
  input  logic               out_ready,
  output logic               out_found,
  output logic [9:0]         out_segment_index,
  output logic signed [17:0] out_position_on_segment,
  output logic [31:0]        out_distance,
  // Configuration port
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  localparam int AW = $clog2(MAX_SEGMENTS + 1);

  pns_pkg::state_t state_r, state_nxt;

  // Configuration registers
  logic [10:0] seg_count_r;
  logic        closed_r;

  // Query control
  logic [AW-1:0] k_r, n_r, n_start;
  logic          pre_r;
  logic [5:0]    cnt_r;

  // Memory ports
  logic          ram_we;
  logic [AW-1:0] ram_waddr, ram_raddr;
  logic [31:0]   rd_x, rd_y;

  // Segment datapath
  logic signed [31:0] qx_r, qy_r, x0_r, y0_r;
  logic signed [32:0] dx_r, dy_r, ex_r, ey_r;
  logic signed [32:0] mul_a, mul_b;
  logic signed [65:0] prod_r;
  logic [65:0]        len_r;
  logic signed [67:0] dot_r, crs_r;
  logic [66:0]        cmag_r;
  logic               zero_r, before_r, beyond_r, inrange_r;
  logic [66:0]        prem_r, prem_sh;
  logic               pge;
  logic [17:0]        pq_r;
  logic [65:0]        sq_src_r;
  logic [35:0]        sq_rem_r, sq_sh, sq_trial;
  logic               sge;
  logic [32:0]        root_r;
  logic [66:0]        drem_r, dv_r;
  logic               dge;
  logic [31:0]        dq_r, dist_r;
  logic signed [17:0] psi_cur;

  // Running best and previous segment
  logic               have_r, have_nxt;
  logic [31:0]        best_d_r, best_d_nxt;
  logic [AW-1:0]      best_k_r, best_k_nxt;
  logic signed [17:0] best_psi_r, best_psi_nxt;
  logic               prev_ok_r, prev_beyond_r;
  logic [31:0]        prev_d_r;
  logic [AW-1:0]      prev_k_r;

  logic               out_valid_r;
  logic               out_found_r;
  logic [9:0]         out_seg_r;
  logic signed [17:0] out_psi_r;
  logic [31:0]        out_dist_r;

  logic in_fire, cfg_wr, last_seg, out_free;

  // Vertex memories
  pns_ram #(.WIDTH(32), .DEPTH(MAX_SEGMENTS + 1)) u_ram_x (
    .clk(clk), .we(ram_we), .waddr(ram_waddr), .wdata(in_coord_x),
    .raddr(ram_raddr), .rdata(rd_x)
  );

  pns_ram #(.WIDTH(32), .DEPTH(MAX_SEGMENTS + 1)) u_ram_y (
    .clk(clk), .we(ram_we), .waddr(ram_waddr), .wdata(in_coord_y),
    .raddr(ram_raddr), .rdata(rd_y)
  );

  // Configuration access
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_comb begin
    case (paddr[2])
      pns_pkg::REG_SEGMENT_COUNT: prdata = {21'd0, seg_count_r};
      pns_pkg::REG_CLOSED_LOOP:   prdata = {31'd0, closed_r};
      default:                    prdata = 32'd0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seg_count_r <= 11'd1;
      closed_r    <= 1'b0;
    end else if (cfg_wr) begin
      case (paddr[2])
        pns_pkg::REG_SEGMENT_COUNT: seg_count_r <= pwdata[10:0];
        pns_pkg::REG_CLOSED_LOOP:   closed_r    <= pwdata[0];
        default: ;
      endcase
    end
  end

  // Handshake and sequencing helpers
  assign in_fire  = in_valid && in_ready;
  assign out_free = !out_valid_r || out_ready;
  assign last_seg = !pre_r && ((k_r + 1'b1) == n_r);
  assign n_start  = (32'(seg_count_r) > MAX_SEGMENTS) ? AW'(MAX_SEGMENTS)
                                                      : AW'(seg_count_r);

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      pns_pkg::ST_IDLE: begin
        if (in_fire && in_kind == pns_pkg::KIND_QUERY) begin
          state_nxt = (n_start == '0) ? pns_pkg::ST_DONE : pns_pkg::ST_RDA;
        end
      end
      pns_pkg::ST_RDA:  state_nxt = pns_pkg::ST_RDB;
      pns_pkg::ST_RDB:  state_nxt = pns_pkg::ST_DIFF;
      pns_pkg::ST_DIFF: state_nxt = pns_pkg::ST_MUL;
      pns_pkg::ST_MUL: begin
        if (cnt_r == 6'(pns_pkg::MUL_STEPS - 1)) state_nxt = pns_pkg::ST_CHK;
      end
      pns_pkg::ST_CHK: begin
        if (len_r == '0) begin
          state_nxt = pns_pkg::ST_UPD;
        end else if (!dot_r[67] && dot_r < $signed({2'b00, len_r})) begin
          state_nxt = pns_pkg::ST_PSI;
        end else begin
          state_nxt = pns_pkg::ST_SQRT;
        end
      end
      pns_pkg::ST_PSI: begin
        if (cnt_r == 6'(pns_pkg::PSI_STEPS - 1)) state_nxt = pns_pkg::ST_SQRT;
      end
      pns_pkg::ST_SQRT: begin
        if (cnt_r == 6'(pns_pkg::SQRT_STEPS - 1)) state_nxt = pns_pkg::ST_DSET;
      end
      pns_pkg::ST_DSET: begin
        state_nxt = (cmag_r >= {1'b0, root_r, 32'd0}) ? pns_pkg::ST_UPD : pns_pkg::ST_DIV;
      end
      pns_pkg::ST_DIV: begin
        if (cnt_r == 6'(pns_pkg::DIV_STEPS - 1)) state_nxt = pns_pkg::ST_UPD;
      end
      pns_pkg::ST_UPD:  state_nxt = last_seg ? pns_pkg::ST_DONE : pns_pkg::ST_RDA;
      pns_pkg::ST_DONE: if (out_free) state_nxt = pns_pkg::ST_IDLE;
      default:          state_nxt = pns_pkg::ST_IDLE;
    endcase
  end

  // Control outputs: ready, memory write and read addresses
  always_comb begin
    in_ready  = 1'b0;
    ram_we    = 1'b0;
    ram_waddr = AW'(in_vertex_index);
    ram_raddr = k_r;
    case (state_r)
      pns_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        ram_we   = in_valid && in_kind == pns_pkg::KIND_LOAD &&
                   32'(in_vertex_index) <= MAX_SEGMENTS;
      end
      pns_pkg::ST_RDB: ram_raddr = k_r + 1'b1;
      default: ;
    endcase
  end

  // Shared multiplier operand selection
  always_comb begin
    case (cnt_r)
      6'd0:    begin mul_a = dx_r; mul_b = dx_r; end
      6'd1:    begin mul_a = dy_r; mul_b = dy_r; end
      6'd2:    begin mul_a = ex_r; mul_b = dx_r; end
      6'd3:    begin mul_a = ey_r; mul_b = dy_r; end
      6'd4:    begin mul_a = dx_r; mul_b = ey_r; end
      6'd5:    begin mul_a = dy_r; mul_b = ex_r; end
      default: begin mul_a = '0;   mul_b = '0;   end
    endcase
  end

  // One step of each iterative unit
  assign prem_sh  = {prem_r[65:0], 1'b0};
  assign pge      = prem_sh >= {1'b0, len_r};
  assign sq_sh    = {sq_rem_r[33:0], sq_src_r[65:64]};
  assign sq_trial = {1'b0, root_r, 2'b01};
  assign sge      = sq_sh >= sq_trial;
  assign dge      = drem_r >= dv_r;
  assign psi_cur  = $signed(pq_r) - pns_pkg::PSI_ONE;

  // Best-segment selection for the segment just finished
  always_comb begin
    have_nxt     = have_r;
    best_d_nxt   = best_d_r;
    best_k_nxt   = best_k_r;
    best_psi_nxt = best_psi_r;
    if (!zero_r && !pre_r) begin
      if (before_r && prev_ok_r && prev_beyond_r) begin
        // Corner between two segments: start of this one, then end of the previous.
        if (!have_nxt || dist_r < best_d_nxt) begin
          have_nxt     = 1'b1;
          best_d_nxt   = dist_r;
          best_k_nxt   = k_r;
          best_psi_nxt = -pns_pkg::PSI_ONE;
        end
        if (prev_d_r < best_d_nxt) begin
          best_d_nxt   = prev_d_r;
          best_k_nxt   = prev_k_r;
          best_psi_nxt = pns_pkg::PSI_ONE;
        end
      end else if (inrange_r) begin
        if (!have_nxt || dist_r < best_d_nxt) begin
          have_nxt     = 1'b1;
          best_d_nxt   = dist_r;
          best_k_nxt   = k_r;
          best_psi_nxt = psi_cur;
        end
      end
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= pns_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
      cnt_r       <= '0;
    end else begin
      state_r <= state_nxt;
      if (state_nxt != state_r) begin
        cnt_r <= '0;
      end else begin
        cnt_r <= cnt_r + 1'b1;
      end
      if (state_r == pns_pkg::ST_DONE && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    case (state_r)
      pns_pkg::ST_IDLE: begin
        qx_r      <= in_coord_x;
        qy_r      <= in_coord_y;
        n_r       <= n_start;
        have_r    <= 1'b0;
        best_d_r  <= '0;
        best_k_r  <= '0;
        best_psi_r <= '0;
        prev_ok_r <= 1'b0;
        prev_beyond_r <= 1'b0;
        prev_d_r  <= '0;
        prev_k_r  <= '0;
        pre_r     <= closed_r;
        k_r       <= closed_r ? n_start - 1'b1 : '0;
      end
      pns_pkg::ST_RDB: begin
        x0_r <= $signed(rd_x);
        y0_r <= $signed(rd_y);
      end
      pns_pkg::ST_DIFF: begin
        dx_r <= 33'($signed(rd_x)) - 33'(x0_r);
        dy_r <= 33'($signed(rd_y)) - 33'(y0_r);
        ex_r <= 33'(qx_r) - 33'(x0_r);
        ey_r <= 33'(qy_r) - 33'(y0_r);
      end
      pns_pkg::ST_MUL: begin
        prod_r <= mul_a * mul_b;
        case (cnt_r)
          6'd1: len_r <= $unsigned(prod_r);
          6'd2: len_r <= len_r + $unsigned(prod_r);
          6'd3: dot_r <= 68'(prod_r);
          6'd4: dot_r <= dot_r + 68'(prod_r);
          6'd5: crs_r <= 68'(prod_r);
          6'd6: crs_r <= crs_r - 68'(prod_r);
          default: ;
        endcase
      end
      pns_pkg::ST_CHK: begin
        zero_r    <= len_r == '0;
        before_r  <= dot_r[67] || dot_r == '0;
        beyond_r  <= !dot_r[67] && dot_r >= $signed({2'b00, len_r});
        inrange_r <= !dot_r[67] && dot_r <= $signed({2'b00, len_r});
        cmag_r    <= crs_r[67] ? 67'(-crs_r) : 67'(crs_r);
        prem_r    <= dot_r[66:0];
        pq_r      <= (dot_r == $signed({2'b00, len_r})) ? 18'h20000 : 18'd0;
        sq_src_r  <= len_r;
        sq_rem_r  <= '0;
        root_r    <= '0;
      end
      pns_pkg::ST_PSI: begin
        prem_r <= pge ? prem_sh - {1'b0, len_r} : prem_sh;
        pq_r   <= {pq_r[16:0], pge};
      end
      pns_pkg::ST_SQRT: begin
        sq_rem_r <= sge ? sq_sh - sq_trial : sq_sh;
        root_r   <= {root_r[31:0], sge};
        sq_src_r <= {sq_src_r[63:0], 2'b00};
      end
      pns_pkg::ST_DSET: begin
        drem_r <= cmag_r;
        dv_r   <= {3'b000, root_r, 31'd0};
        dq_r   <= '0;
        dist_r <= 32'hFFFF_FFFF;
      end
      pns_pkg::ST_DIV: begin
        drem_r <= dge ? drem_r - dv_r : drem_r;
        dv_r   <= {1'b0, dv_r[66:1]};
        dq_r   <= {dq_r[30:0], dge};
        if (cnt_r == 6'(pns_pkg::DIV_STEPS - 1)) dist_r <= {dq_r[30:0], dge};
      end
      pns_pkg::ST_UPD: begin
        have_r     <= have_nxt;
        best_d_r   <= best_d_nxt;
        best_k_r   <= best_k_nxt;
        best_psi_r <= best_psi_nxt;
        if (!zero_r) begin
          prev_ok_r     <= 1'b1;
          prev_beyond_r <= beyond_r;
          prev_d_r      <= dist_r;
          prev_k_r      <= k_r;
        end
        pre_r <= 1'b0;
        k_r   <= pre_r ? '0 : k_r + 1'b1;
      end
      pns_pkg::ST_DONE: begin
        if (out_free) begin
          out_found_r <= have_r;
          out_seg_r   <= have_r ? 10'(best_k_r) : 10'd0;
          out_psi_r   <= have_r ? best_psi_r : 18'sd0;
          out_dist_r  <= have_r ? best_d_r : 32'd0;
        end
      end
      default: ;
    endcase
  end

  assign out_valid               = out_valid_r;
  assign out_found               = out_found_r;
  assign out_segment_index       = out_seg_r;
  assign out_position_on_segment = out_psi_r;
  assign out_distance            = out_dist_r;

`ifndef SYNTHESIS
  // A result without a nearest segment carries all-zero fields.
  a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_found |->
      out_segment_index == 10'd0 && out_distance == 32'd0 &&
      out_position_on_segment == 18'sd0)
    else $error("empty result with nonzero fields");

  // The reported position stays within one segment.
  a_psi_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_position_on_segment >= -pns_pkg::PSI_ONE &&
                  out_position_on_segment <= pns_pkg::PSI_ONE)
    else $error("position out of range");

  // The segment walk never passes the number of segments in use.
  a_walk_bound: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == pns_pkg::ST_RDA |-> k_r < n_r)
    else $error("segment index beyond count");

  // A finished query hands its result over the cycle it leaves the done state.
  a_done_result: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == pns_pkg::ST_DONE && out_free |=> out_valid)
    else $error("result lost");
`endif

endmodule

[bench/testbench.sv]
module testbench;

  localparam int NVERT = pns_pkg::MAX_SEGMENTS_DEF + 1;
  localparam logic [2:0] ADDR_SEGMENT_COUNT = {1'b0, pns_pkg::REG_SEGMENT_COUNT, 1'b0} << 1;
  localparam logic [2:0] ADDR_CLOSED_LOOP = {1'b0, pns_pkg::REG_CLOSED_LOOP, 1'b0} << 1;
  localparam int PSI_UNIT = 65536;

  // Predicts the nearest segment for each query and checks the results in order.
  class nearest_segment_board;
    logic [31:0] vx[NVERT];
    logic [31:0] vy[NVERT];
    int unsigned seg_count;
    bit closed;
    logic [60:0] pending_q[$];
    int mismatches;

    function new();
      seg_count = 1;
      closed = 0;
      mismatches = 0;
    endfunction

    function void set_register(logic [2:0] addr, logic [31:0] data);
      if (addr == ADDR_SEGMENT_COUNT) seg_count = data[10:0];
      else if (addr == ADDR_CLOSED_LOOP) closed = data[0];
    endfunction

    // Floor square root of a value below 2^66.
    function automatic logic signed [127:0] root(logic signed [127:0] v);
      logic signed [127:0] r, c;
      r = 0;
      for (int b = 32; b >= 0; b--) begin
        c = r | (128'sd1 << b);
        if (c * c <= v) r = c;
      end
      return r;
    endfunction

    // Projects a point on segment k; ok is low for a zero-length segment.
    function automatic void project(int k, longint qx, longint qy, output bit ok,
                                    output bit bef, output bit bey, output bit inr,
                                    output int psi, output logic [31:0] dist_val);
      logic signed [127:0] x0, y0, dx, dy, ex, ey, len2, dot, crs, s, q;
      x0 = $signed(vx[k]);
      y0 = $signed(vy[k]);
      dx = $signed(vx[k + 1]) - x0;
      dy = $signed(vy[k + 1]) - y0;
      ex = qx - x0;
      ey = qy - y0;
      len2 = dx * dx + dy * dy;
      ok = (len2 != 0);
      bef = 0; bey = 0; inr = 0; psi = 0; dist_val = 0;
      if (!ok) return;
      dot = ex * dx + ey * dy;
      crs = dx * ey - dy * ex;
      if (crs < 0) crs = -crs;
      bef = (dot <= 0);
      bey = (dot >= len2);
      inr = (dot >= 0) && (dot <= len2);
      if (inr) begin
        q = (dot == len2) ? 128'sd131072 : (dot <<< 17) / len2;
        psi = int'(q) - PSI_UNIT;
      end
      s = root(len2);
      if (crs >= (s <<< 32)) dist_val = 32'hFFFF_FFFF;
      else dist_val = 32'(crs / s);
    endfunction

    // Notes an accepted request: a load updates the store, a query adds a result.
    function automatic void note_request(logic kind, logic [10:0] idx, logic [31:0] cx,
                                         logic [31:0] cy);
      int unsigned n;
      longint qx, qy;
      bit have, prev_ok, prev_bey, ok, bef, bey, inr;
      logic [31:0] best_d, prev_d, d;
      int best_k, prev_k, best_psi, psi;
      if (kind == pns_pkg::KIND_LOAD) begin
        if (idx <= pns_pkg::MAX_SEGMENTS_DEF) begin
          vx[idx] = cx;
          vy[idx] = cy;
        end
        return;
      end
      qx = $signed(cx);
      qy = $signed(cy);
      n = (seg_count > pns_pkg::MAX_SEGMENTS_DEF) ? pns_pkg::MAX_SEGMENTS_DEF : seg_count;
      have = 0; prev_ok = 0; prev_bey = 0;
      best_d = 0; best_k = 0; best_psi = 0; prev_d = 0; prev_k = 0;
      if (closed && n > 0) begin
        project(n - 1, qx, qy, ok, bef, bey, inr, psi, d);
        if (ok) begin
          prev_ok = 1; prev_bey = bey; prev_d = d; prev_k = n - 1;
        end
      end
      for (int k = 0; k < n; k++) begin
        project(k, qx, qy, ok, bef, bey, inr, psi, d);
        if (!ok) continue;
        if (bef && prev_ok && prev_bey) begin
          // Corner between two segments: start of this one, then end of the last.
          if (!have || d < best_d) begin
            have = 1; best_d = d; best_k = k; best_psi = -PSI_UNIT;
          end
          if (prev_d < best_d) begin
            best_d = prev_d; best_k = prev_k; best_psi = PSI_UNIT;
          end
        end else if (inr) begin
          if (!have || d < best_d) begin
            have = 1; best_d = d; best_k = k; best_psi = psi;
          end
        end
        prev_ok = 1; prev_bey = bey; prev_d = d; prev_k = k;
      end
      if (have) pending_q.push_back({1'b1, 10'(best_k), 18'(best_psi), best_d});
      else pending_q.push_back('0);
    endfunction

    function automatic void check_result(logic found, logic [9:0] idx, logic [17:0] psi,
                                         logic [31:0] dist_val);
      logic [60:0] exp_r, got;
      got = {found, idx, psi, dist_val};
      if (pending_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result: found=%0d seg=%0d psi=%0d dist=%h",
                                       found, idx, $signed(psi), dist_val);
        return;
      end
      exp_r = pending_q.pop_front();
      if (exp_r !== got) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch: expected found=%0d seg=%0d psi=%0d dist=%h, got found=%0d seg=%0d psi=%0d dist=%h",
                   exp_r[60], exp_r[59:50], $signed(exp_r[49:32]), exp_r[31:0],
                   found, idx, $signed(psi), dist_val);
      end
    endfunction
  endclass

  logic clk = 0;
  logic rst_n = 0;
  logic in_valid = 0;
  logic in_ready;
  logic in_kind = 0;
  logic [10:0] in_vertex_index = 0;
  logic signed [31:0] in_coord_x = 0;
  logic signed [31:0] in_coord_y = 0;
  logic out_valid;
  logic out_ready = 0;
  logic out_found;
  logic [9:0] out_segment_index;
  logic signed [17:0] out_position_on_segment;
  logic [31:0] out_distance;
  logic psel = 0, penable = 0, pwrite = 0;
  logic [2:0] paddr = 0;
  logic [31:0] pwdata = 0;
  logic [31:0] prdata;
  logic pready;

  nearest_segment_board board = new();
  logic [31:0] shadow_x[NVERT];
  logic [31:0] shadow_y[NVERT];
  bit no_gaps;
  int stall_left = 0;

  polyline_nearest_segment_search uut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_kind(in_kind),
    .in_vertex_index(in_vertex_index), .in_coord_x(in_coord_x), .in_coord_y(in_coord_y),
    .out_valid(out_valid), .out_ready(out_ready), .out_found(out_found),
    .out_segment_index(out_segment_index), .out_position_on_segment(out_position_on_segment),
    .out_distance(out_distance),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata),
    .prdata(prdata), .pready(pready)
  );

  always #6 clk = ~clk;

  // Mostly short gaps, now and then a long one.
  function automatic int gap_len();
    if (no_gaps) return 0;
    if ($urandom_range(0, 9) < 7) return $urandom_range(0, 2);
    if ($urandom_range(0, 9) < 8) return $urandom_range(3, 8);
    return $urandom_range(20, 60);
  endfunction

  // Result side backpressure.
  always @(negedge clk) begin
    if (stall_left > 0) begin
      stall_left--;
      out_ready = 0;
    end else if ($urandom_range(0, 3) == 0) begin
      stall_left = gap_len();
      out_ready = (stall_left == 0);
    end else begin
      out_ready = 1;
    end
  end

  // Watch both channels at the rising edge.
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready)
        board.note_request(in_kind, in_vertex_index, in_coord_x, in_coord_y);
      if (out_valid && out_ready)
        board.check_result(out_found, out_segment_index, out_position_on_segment,
                           out_distance);
    end
  end

  // Sends one request; returns at the falling edge after it was accepted, or later when a random gap follows.
  task automatic send(logic kind, logic [10:0] idx, logic [31:0] x, logic [31:0] y);
    int g;
    in_valid = 1;
    in_kind = kind;
    in_vertex_index = idx;
    in_coord_x = x;
    in_coord_y = y;
    if (kind == pns_pkg::KIND_LOAD && idx <= pns_pkg::MAX_SEGMENTS_DEF) begin
      shadow_x[idx] = x;
      shadow_y[idx] = y;
    end
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
    g = gap_len();
    if (g > 0) begin
      in_valid = 0;
      repeat (g) @(negedge clk);
    end
  endtask

  task automatic load(int idx, logic [31:0] x, logic [31:0] y);
    send(pns_pkg::KIND_LOAD, 11'(idx), x, y);
  endtask

  task automatic query(logic [31:0] x, logic [31:0] y);
    send(pns_pkg::KIND_QUERY, 11'd0, x, y);
  endtask

  // Waits until the block has drained before a register write.
  task automatic settle();
    in_valid = 0;
    while (board.pending_q.size() != 0) @(negedge clk);
    repeat (120) @(negedge clk);
  endtask

  task automatic cfg_write(logic [2:0] addr, logic [31:0] data);
    psel = 1;
    pwrite = 1;
    paddr = addr;
    pwdata = data;
    @(negedge clk);
    penable = 1;
    @(posedge clk);
    board.set_register(addr, data);
    @(negedge clk);
    psel = 0;
    penable = 0;
  endtask

  task automatic configure(int count, bit loop);
    settle();
    cfg_write(ADDR_SEGMENT_COUNT, count);
    cfg_write(ADDR_CLOSED_LOOP, loop);
  endtask

  // Random coordinate at a given number of magnitude bits.
  function automatic logic [31:0] coord(int bits);
    return $signed($urandom) >>> (31 - bits);
  endfunction

  // One phase: a random polyline and queries placed around it.
  task automatic random_phase();
    int n, bits, nq, k, off;
    logic [31:0] x, y;
    n = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 8);
    bits = $urandom_range(0, 3) == 0 ? 31 : $urandom_range(8, 24);
    off = (bits > 4) ? bits - 3 : 1;
    no_gaps = ($urandom_range(0, 3) == 0);
    configure(n, $urandom_range(0, 1));
    for (int i = 0; i <= n; i++) begin
      if (i > 0 && $urandom_range(0, 7) == 0) load(i, shadow_x[i - 1], shadow_y[i - 1]);
      else load(i, coord(bits), coord(bits));
    end
    nq = $urandom_range(25, 35);
    for (int j = 0; j < nq; j++) begin
      k = $urandom_range(0, n);
      case ($urandom_range(0, 5))
        0: query(shadow_x[k], shadow_y[k]);
        1, 2: query(shadow_x[k] + coord(off), shadow_y[k] + coord(off));
        3: begin
          k = (k == n && n > 0) ? k - 1 : k;
          x = ($signed(shadow_x[k]) >>> 1) + ($signed(shadow_x[k + (n > 0)]) >>> 1);
          y = ($signed(shadow_y[k]) >>> 1) + ($signed(shadow_y[k + (n > 0)]) >>> 1);
          query(x + coord(off), y + coord(off));
        end
        4: query(coord(bits), coord(bits));
        default: begin
          // Noise: ignored slots, or a full-range query.
          if ($urandom_range(0, 1)) load($urandom_range(pns_pkg::MAX_SEGMENTS_DEF + 1, 2047),
                                         $urandom, $urandom);
          else query($urandom, $urandom);
        end
      endcase
    end
  endtask

  initial begin
    #(12 * 4000000);
    $display("simulation failed");
    $finish;
  end

  initial begin
    no_gaps = 1;
    repeat (2) @(negedge clk);
    rst_n = 1;
    no_gaps = 0;

    // No segment in use.
    configure(0, 0);
    query(32'h0, 32'h0);

    // One unit segment: inside, before start, exactly at the end and at the start.
    configure(1, 0);
    load(0, 32'h0, 32'h0);
    load(1, 32'h0001_0000, 32'h0);
    query(32'h0000_8000, 32'h0001_0000);
    query(32'hFFFF_0000, 32'h0);
    query(32'h0001_0000, 32'h0);
    query(32'h0000_0000, 32'h0000_0000);

    // Extreme coordinates exercise the full coordinate range.
    load(0, 32'h8000_0000, 32'h8000_0000);
    load(1, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
    query(32'h8000_0000, 32'h7FFF_FFFF);
    query(32'h7FFF_FFFF, 32'h8000_0000);

    // Outside corner of an L shape, open then closed.
    configure(2, 0);
    load(0, 32'h0, 32'h0);
    load(1, 32'h0001_0000, 32'h0);
    load(2, 32'h0001_0000, 32'h0001_0000);
    query(32'h0002_0000, 32'hFFFF_0000);
    configure(2, 1);
    query(32'hFFFF_0000, 32'hFFFF_8000);

    // Zero-length segment in the middle and as the closing segment.
    configure(3, 1);
    load(3, 32'h0001_0000, 32'h0001_0000);
    query(32'h0002_0000, 32'h0000_8000);
    query(32'hFFFF_8000, 32'hFFFF_8000);
    load(2, 32'h0001_0000, 32'h0);
    query(32'h0001_8000, 32'h0000_4000);

    // Ignored slots.
    load(2047, 32'h1234_5678, 32'h0);
    load(pns_pkg::MAX_SEGMENTS_DEF + 1, 32'h0, 32'h0);
    query(32'h0000_4000, 32'h0000_4000);

    for (int p = 0; p < 14; p++) random_phase();

    in_valid = 0;
    while (board.pending_q.size() != 0) @(negedge clk);
    repeat (200) @(negedge clk);
    if (board.mismatches == 0 && board.pending_q.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end
endmodule
